// ----- hw/rtl/sspc_pkg.sv -----
package sspc_pkg;

	localparam int POS_W = 16;
	localparam int PER_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam int PROD_W = 2 * PER_W;
	localparam int DIV_CNT_W = $clog2(PROD_W);

	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 24;

	// Full-scale teleop rate in Q2.14, and the calibration fraction of four fifths of the span.
	localparam logic [16:0] RATE_ONE = 17'd16384;
	localparam logic [PER_W-1:0] CAL_NUM = PER_W'(4);
	localparam logic [PER_W-1:0] CAL_DEN = PER_W'(5);

	localparam logic [CFG_W-1:0] RST_STEP_COUNT = CFG_W'(200);
	localparam logic [CFG_W-1:0] RST_MIN_HALF = CFG_W'(500);
	localparam logic [CFG_W-1:0] RST_MAX_HALF = CFG_W'(5000);

	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HALF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HALF = 2'd2;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0,
		OP_GOTO = 3'd1,
		OP_MOVE_GOAL = 3'd2,
		OP_SET_RATE = 3'd3,
		OP_CALIBRATE = 3'd4,
		OP_SET_MODE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		MODE_AUTO = 2'd0,
		MODE_TELE = 2'd1,
		MODE_CALIB = 2'd2
	} run_mode_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_CAL_OK = 2'd1,
		EV_CAL_FAIL = 2'd2
	} calib_ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV,
		ST_WB
	} seq_state_t;

endpackage

// ----- hw/rtl/stepper_step_pulse_controller_core.sv -----
// Step-pulse controller for one stepper axis. Each request is a microsecond
// tick or a command, and each yields exactly one response carrying the step
// and direction pin levels, the position count, the mode and the command and
// calibration status. Requests are handled one at a time: a request that does
// not need a new half-period passes through decode and write-back before the
// next acceptance, while an idle auto-mode tick short of the goal, a valid
// non-zero rate command and a calibrate command also pass through the shared
// bit-serial divider (a multiply step, then one divide iteration per quotient bit)
// between decode and write-back. The write-back additionally waits while the
// previous response is still held in the output register.
module stepper_step_pulse_controller_core import sspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// target[15:0], goal_delta[31:16], rate[47:32], mode_request[49:48],
	// limit_switch[50], zero fill[55:51]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// op[2:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// step_out[0], direction_out[1], position[17:2], mode[19:18], status[20],
	// calib_event[22:21], zero fill[23]
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// Configuration registers.
	logic [CFG_W-1:0] step_count_q, min_half_q, max_half_q;

	// Architectural state.
	run_mode_t run_mode_q, n_mode;
	logic [POS_W-1:0] pos_q, goal_q, n_pos, n_goal;
	logic dir_q, n_dir;
	logic [PER_W-1:0] tele_per_q, n_tele_per;
	phase_t phase_q, n_phase;
	logic [PER_W-1:0] cnt_q, n_cnt;
	logic [PER_W-1:0] active_q, n_active;

	// Latched request.
	logic [2:0] op_q;
	logic [POS_W-1:0] target_q;
	logic [15:0] delta_q;
	logic [15:0] rate_q;
	logic [1:0] mreq_q;
	logic limit_q;

	// Shared multiply and divide unit.
	logic [PER_W-1:0] mul_a_q, mul_b_q, divisor_q;
	logic [PROD_W-1:0] quo_q;
	logic [PER_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [PER_W:0] rem_sh;
	logic div_ge;

	// Output register.
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	seq_state_t state_q, state_d;
	logic accept, out_free, ld_item, ld_oper, mul_go, div_go, wb_fire;

	// Derived values shared by decode and write-back.
	logic [PER_W-1:0] span;
	logic busy;
	logic auto_dir;
	logic [POS_W-1:0] pos_step, dist_raw, dist_sat;
	logic [PER_W-1:0] divisor_auto;
	logic rate_neg, rate_bad, rate_zero;
	logic [16:0] rate_mag, rate_k;
	logic [17:0] goal_sum;
	logic goal_ok;
	logic need_div;
	logic [PER_W:0] half_sum;
	logic [PER_W-1:0] half;
	logic status_d;
	calib_ev_t ev_d;

	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= RST_STEP_COUNT;
			min_half_q <= RST_MIN_HALF;
			max_half_q <= RST_MAX_HALF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_COUNT: step_count_q <= cfg_data;
				REG_MIN_HALF: min_half_q <= cfg_data;
				REG_MAX_HALF: max_half_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign span = (max_half_q >= min_half_q) ? (max_half_q - min_half_q) : '0;
	assign busy = (phase_q == PH_HIGH) || (phase_q == PH_LOW);

	// Auto stepping re-aims at the goal before each step.
	assign auto_dir = !(goal_q > pos_q);
	assign pos_step = auto_dir ? (pos_q - POS_W'(1)) : (pos_q + POS_W'(1));
	assign dist_raw = (pos_step > goal_q) ? (pos_step - goal_q) : (goal_q - pos_step);
	assign dist_sat = (dist_raw > step_count_q) ? step_count_q : dist_raw;
	assign divisor_auto = (step_count_q == '0) ? PER_W'(1) : step_count_q;

	assign rate_neg = rate_q[15];
	assign rate_mag = rate_neg ? (17'h10000 - {1'b0, rate_q}) : {1'b0, rate_q};
	assign rate_bad = rate_mag > RATE_ONE;
	assign rate_zero = rate_mag == '0;
	assign rate_k = RATE_ONE - rate_mag;

	assign goal_sum = {2'b00, goal_q} + {{2{delta_q[15]}}, delta_q};
	assign goal_ok = !goal_sum[17] && (goal_sum[16:0] <= {1'b0, step_count_q});

	always_comb begin
		need_div = 1'b0;
		case (op_q)
			OP_TICK: need_div = !busy && (run_mode_q == MODE_AUTO) && (pos_q != goal_q);
			OP_SET_RATE: need_div = !rate_bad && !rate_zero;
			OP_CALIBRATE: need_div = 1'b1;
			default: need_div = 1'b0;
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_DECODE;
			ST_DECODE: state_d = need_div ? ST_MUL : ST_WB;
			ST_MUL: state_d = ST_DIV;
			ST_DIV: if (div_cnt_q == '0) state_d = ST_WB;
			ST_WB: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ld_item = 1'b0;
		ld_oper = 1'b0;
		mul_go = 1'b0;
		div_go = 1'b0;
		wb_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ld_item = s_tvalid;
			end
			ST_DECODE: ld_oper = 1'b1;
			ST_MUL: mul_go = 1'b1;
			ST_DIV: div_go = 1'b1;
			ST_WB: wb_fire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_item) begin
			op_q <= s_tuser;
			target_q <= s_tdata[15:0];
			delta_q <= s_tdata[31:16];
			rate_q <= s_tdata[47:32];
			mreq_q <= s_tdata[49:48];
			limit_q <= s_tdata[50];
		end
	end

	// Operand selection: every half-period is min + span * k / d with k <= d.
	always_ff @(posedge clk) begin
		if (ld_oper) begin
			mul_a_q <= span;
			case (op_q)
				OP_TICK: begin
					mul_b_q <= dist_sat;
					divisor_q <= divisor_auto;
				end
				OP_SET_RATE: begin
					mul_b_q <= rate_k[PER_W-1:0];
					divisor_q <= RATE_ONE[PER_W-1:0];
				end
				default: begin
					mul_b_q <= CAL_NUM;
					divisor_q <= CAL_DEN;
				end
			endcase
		end
	end

	// Restoring divider, one quotient bit per cycle; the dividend shifts out
	// of the top of quo_q as the quotient shifts in at the bottom.
	assign rem_sh = {rem_q, quo_q[PROD_W-1]};
	assign div_ge = rem_sh >= {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (mul_go) begin
			quo_q <= mul_a_q * mul_b_q;
			rem_q <= '0;
			div_cnt_q <= DIV_CNT_W'(PROD_W - 1);
		end else if (div_go) begin
			quo_q <= {quo_q[PROD_W-2:0], div_ge};
			rem_q <= div_ge ? PER_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[PER_W-1:0];
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	assign half_sum = {1'b0, min_half_q} + {1'b0, quo_q[PER_W-1:0]};
	assign half = half_sum[PER_W] ? '1 : half_sum[PER_W-1:0];

	// Write-back: next architectural state and the response fields.
	always_comb begin
		n_mode = run_mode_q;
		n_pos = pos_q;
		n_goal = goal_q;
		n_dir = dir_q;
		n_tele_per = tele_per_q;
		n_phase = phase_q;
		n_cnt = cnt_q;
		n_active = active_q;
		status_d = 1'b0;
		ev_d = EV_NONE;
		case (op_q)
			OP_TICK: begin
				if (busy) begin
					n_cnt = (cnt_q != '0) ? (cnt_q - PER_W'(1)) : '0;
					if (n_cnt == '0) begin
						if (phase_q == PH_HIGH) begin
							n_phase = PH_LOW;
							n_cnt = active_q;
						end else begin
							n_phase = PH_IDLE;
						end
					end
				end else begin
					n_phase = PH_IDLE;
					case (run_mode_q)
						MODE_AUTO: begin
							if (pos_q != goal_q) begin
								n_dir = auto_dir;
								n_pos = pos_step;
								n_active = half;
								n_cnt = half;
								n_phase = PH_HIGH;
							end
						end
						MODE_TELE: begin
							if (tele_per_q != '0) begin
								n_active = tele_per_q;
								n_cnt = tele_per_q;
								n_phase = PH_HIGH;
							end
						end
						MODE_CALIB: begin
							if (limit_q) begin
								n_pos = '0;
								n_goal = '0;
								n_dir = 1'b0;
								n_mode = MODE_AUTO;
								ev_d = EV_CAL_OK;
							end else if (pos_q >= step_count_q) begin
								n_pos = '0;
								n_mode = MODE_AUTO;
								ev_d = EV_CAL_FAIL;
							end else begin
								n_active = tele_per_q;
								n_cnt = tele_per_q;
								n_phase = PH_HIGH;
								n_pos = pos_q + POS_W'(1);
							end
						end
						default: ;
					endcase
				end
			end
			OP_GOTO: begin
				if (target_q >= step_count_q) begin
					status_d = 1'b1;
				end else begin
					if (target_q > pos_q) n_dir = 1'b0;
					else if (target_q < pos_q) n_dir = 1'b1;
					n_goal = target_q;
				end
			end
			OP_MOVE_GOAL: begin
				if (goal_ok) n_goal = goal_sum[POS_W-1:0];
				else status_d = 1'b1;
			end
			OP_SET_RATE: begin
				if (rate_bad) begin
					n_tele_per = '0;
					status_d = 1'b1;
				end else if (rate_zero) begin
					n_tele_per = '0;
				end else begin
					n_dir = rate_neg;
					n_tele_per = half;
				end
			end
			OP_CALIBRATE: begin
				n_tele_per = half;
				n_mode = MODE_CALIB;
				n_pos = '0;
				n_goal = '0;
				n_dir = 1'b0;
			end
			OP_SET_MODE: begin
				case (mreq_q)
					MODE_AUTO, MODE_TELE, MODE_CALIB: n_mode = run_mode_t'(mreq_q);
					default: status_d = 1'b1;
				endcase
			end
			default: status_d = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q <= MODE_AUTO;
			pos_q <= '0;
			goal_q <= '0;
			dir_q <= 1'b0;
			tele_per_q <= '0;
			phase_q <= PH_IDLE;
			cnt_q <= '0;
			active_q <= '0;
		end else if (wb_fire) begin
			run_mode_q <= n_mode;
			pos_q <= n_pos;
			goal_q <= n_goal;
			dir_q <= n_dir;
			tele_per_q <= n_tele_per;
			phase_q <= n_phase;
			cnt_q <= n_cnt;
			active_q <= n_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (wb_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			m_tdata_q <= {1'b0, ev_d, status_d, n_mode, n_pos, n_dir, n_phase == PH_HIGH};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// ----- hw/rtl/sspc_checker.sv -----
module sspc_checker import sspc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A held response must not change under back-pressure.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response changed while stalled");

	// Requests are processed one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in progress");

	// A calibration outcome always leaves the axis in auto mode.
	a_cal_to_auto: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[22:21] != EV_NONE) |-> m_tdata[19:18] == MODE_AUTO)
		else $error("calibration ended outside auto mode");

	// A successful calibration homes the axis forward at position zero.
	a_cal_home: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[22:21] == EV_CAL_OK) |-> m_tdata[17:2] == '0 && !m_tdata[1])
		else $error("calibration success without homing");

	// Only ticks raise calibration events, and ticks are never rejected.
	a_ev_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> m_tdata[22:21] == EV_NONE)
		else $error("rejected request carries a calibration event");

endmodule

bind stepper_step_pulse_controller_core sspc_checker u_sspc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
